FILE: sv/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared types, constants and the letter lookup of the triplet text decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

	localparam int RTD_FIFO_DEPTH = 4;
	localparam int TOKEN_W        = 15;
	localparam int LETTER_W       = 5;
	localparam int ALPHA_LEN      = 26;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_TOKEN  = 2'd1,
		PH_ESCAPE = 2'd2,
		PH_RUN    = 2'd3
	} phase_t;

	typedef enum logic {
		CMD_LIT   = 1'b0,
		CMD_TOKEN = 1'b1
	} cmd_kind_t;

	// one decoded command; a literal or run uses value/count, a token uses token
	typedef struct packed {
		cmd_kind_t          kind;
		logic [TOKEN_W-1:0] token;
		logic [7:0]         value;
		logic [6:0]         count;
	} cmd_t;

	// A..Z, indices past the alphabet give zero
	function automatic logic [7:0] letter_of(input logic [LETTER_W-1:0] idx);
		logic [7:0] res;
		if (idx < LETTER_W'(ALPHA_LEN))
			res = 8'h41 + {3'b000, idx};
		else
			res = 8'h00;
		return res;
	endfunction

endpackage

FILE: sv/rtd_front.sv
// ----------------------------------------------------------------------------
// rtd_front
// Byte parser: tracks the code phase and turns bytes into decode commands.
// ----------------------------------------------------------------------------
module rtd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    in_byte,
	output logic          cmd_valid,
	output rtd_pkg::cmd_t cmd
);
	import rtd_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
		end else if (take) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	always_comb begin
		phase_d   = PH_IDLE;
		held_d    = held_q;
		cmd_valid = 1'b0;
		cmd.kind  = CMD_LIT;
		cmd.token = {held_q[6:0], in_byte};
		cmd.value = in_byte;
		cmd.count = 7'd1;
		case (phase_q)
			PH_IDLE: begin
				if (in_byte[7]) begin
					held_d  = in_byte;
					phase_d = PH_TOKEN;
				end else if (in_byte == 8'h00) begin
					phase_d = PH_ESCAPE;
				end else begin
					cmd_valid = take;
				end
			end
			PH_TOKEN: begin
				cmd.kind  = CMD_TOKEN;
				cmd_valid = take;
			end
			PH_ESCAPE: begin
				if (!in_byte[7]) begin
					held_d  = in_byte;
					phase_d = PH_RUN;
				end else begin
					cmd_valid = take;
				end
			end
			PH_RUN: begin
				// zero count: value byte is swallowed
				cmd.count = held_q[6:0];
				cmd_valid = take && (held_q[6:0] != 7'd0);
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/rtd_fifo.sv
// ----------------------------------------------------------------------------
// rtd_fifo
// Short command queue between parser and result sequencer.
// ----------------------------------------------------------------------------
module rtd_fifo #(
	parameter int DEPTH = rtd_pkg::RTD_FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  rtd_pkg::cmd_t wr_data,
	input  logic          rd_en,
	output rtd_pkg::cmd_t rd_data,
	output logic          full,
	output logic          empty
);
	import rtd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1))
			r = '0;
		else
			r = p + PTR_W'(1);
		return r;
	endfunction

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= bump(wr_ptr_q);
			if (rd_en)
				rd_ptr_q <= bump(rd_ptr_q);
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

FILE: sv/rtd_back.sv
// ----------------------------------------------------------------------------
// rtd_back
// Result sequencer: holds one command and emits its one or three beats.
// ----------------------------------------------------------------------------
module rtd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rtd_pkg::cmd_t q_data,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic [6:0]    repeat_res,
	output logic          last
);
	import rtd_pkg::*;

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] step_q;
	logic       advance;
	logic [LETTER_W-1:0] idx;

	assign empty = !cur_valid_q;

	always_comb begin
		case (step_q)
			2'd0:    idx = cur_q.token[14:10];
			2'd1:    idx = cur_q.token[9:5];
			default: idx = cur_q.token[4:0];
		endcase
		if (cur_q.kind == CMD_TOKEN) begin
			out_byte   = letter_of(idx);
			repeat_res = 7'd1;
			last       = (step_q == 2'd2);
		end else begin
			out_byte   = cur_q.value;
			repeat_res = cur_q.count;
			last       = 1'b1;
		end
	end

	// slot frees when empty or its final beat leaves
	assign advance = !cur_valid_q || (pop && last);
	assign q_pop   = advance && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= 2'd0;
		end else if (advance) begin
			cur_valid_q <= !q_empty;
			step_q      <= 2'd0;
		end else if (pop) begin
			step_q <= step_q + 2'd1;
		end
	end

endmodule

FILE: sv/rle_triplet_text_decompressor.sv
// ----------------------------------------------------------------------------
// rle_triplet_text_decompressor
// Decodes a run-length / letter-triplet byte stream into result beats.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------
//  input   | push / full        | in_byte[7:0]
//  result  | empty / pop        | out_byte[7:0] repeat_res[6:0] last
//
//  One input byte per cycle is taken while the command queue has room.
//  Literals, escapes and runs give one result beat (a run with a zero
//  count gives none); a token gives three, one per cycle while pop is
//  held, so the result side sets the rate. Runs leave as one beat
//  with the count in repeat_res; they are not expanded.
//  Reset (arst_n low) drops pending partial codes and queued commands.
//  Either side may stall freely: the queue of FIFO_DEPTH commands and the
//  sequencer's hold register decouple them.
//
module rle_triplet_text_decompressor #(
	parameter int FIFO_DEPTH = rtd_pkg::RTD_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic [6:0] repeat_res,
	output logic       last
);
	import rtd_pkg::*;

	logic take;
	logic cmd_valid;
	cmd_t cmd;
	cmd_t q_data;
	logic q_full, q_empty, q_pop;

	// front stalls only on a full queue
	assign full = q_full;
	assign take = push && !q_full;

	rtd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	rtd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	rtd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_data),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.repeat_res (repeat_res),
		.last       (last)
	);

	// a result beat never carries a zero count
	a_repeat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (repeat_res != 7'd0))
		else $error("result beat with zero repeat count");

	// a token's inner beat is always followed at once by the next letter
	a_token_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=> !empty)
		else $error("token letters interrupted");

	// queue never claims full and empty together
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("command queue full and empty");

	// nothing is queued from a byte that was refused
	a_no_write_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !cmd_valid)
		else $error("command written into full queue");

endmodule
